// ----- src/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants, codes and controller/datapath interface types for the
// counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

  // default table sizes
  localparam int NUM_SEMS_DEF      = 16;
  localparam int SLOTS_DEF         = 8;
  localparam int NUM_PROCESSES_DEF = 64;

  // field widths
  localparam int KIND_W   = 3;
  localparam int PID_W    = 6;
  localparam int ID_W     = 5;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 4;
  localparam int REF_W    = 10;

  localparam logic [REF_W-1:0]        REF_MAX = 10'd1023;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;
  localparam logic [ID_W-1:0]         ID_NEW  = 5'h1F;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_GET      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UP       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FREE_ALL = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_ID      = 3'd1,
    ST_NONE_FREE   = 3'd2,
    ST_NO_SLOT     = 3'd3,
    ST_NOT_HELD    = 3'd4,
    ST_WOULD_BLOCK = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SEL_ZERO   = 2'd0,
    SEL_ID     = 2'd1,
    SEL_CHOSEN = 2'd2
  } idx_sel_t;

  typedef struct packed {
    logic     req_load;
    logic     clr_wr;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     found_clr;
    logic     slot_rd;
    logic     slot_scan;
    logic     slot_clr_held;
    logic     slot_clr_cur;
    logic     slot_attach;
    logic     ref_rd_id;
    logic     ref_rd_scan;
    logic     ref_rd_chosen;
    logic     ref_rd_slot;
    logic     ref_wr_inc_chosen;
    logic     ref_wr_dec_id;
    logic     ref_wr_dec_slot;
    logic     chosen_from_id;
    logic     val_rd;
    logic     val_wr_init;
    logic     val_wr_down;
    logic     val_wr_up;
    logic     out_load;
    status_t  out_status;
    idx_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              bad_id;
    logic              id_new;
    logic              held_found;
    logic              free_found;
    logic              chosen_found;
    logic              slot_valid;
    logic              ref_zero;
    logic              val_pos;
    logic              cnt_last_slot;
    logic              cnt_last_sem;
    logic              cnt_last_clr;
    logic              out_busy;
  } stat_t;

endpackage

// ----- src/cst_ctrl.sv -----
// ----------------------------------------------------------------------------
// cst_ctrl
// Request sequencer: clearing pass, slot scan, free-semaphore scan and the
// read-modify-write steps of each request kind.
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cst_pkg::stat_t stat,
  output cst_pkg::cmd_t  cmd
);
  import cst_pkg::*;

  typedef enum logic [16:0] {
    S_CLEAR         = 17'h00001,
    S_IDLE          = 17'h00002,
    S_DECODE        = 17'h00004,
    S_SCAN_SLOT     = 17'h00008,
    S_SCAN_LAST     = 17'h00010,
    S_DISPATCH      = 17'h00020,
    S_GET_REF       = 17'h00040,
    S_SCAN_REF      = 17'h00080,
    S_SCAN_REF_LAST = 17'h00100,
    S_ALLOC         = 17'h00200,
    S_ATTACH        = 17'h00400,
    S_FREE_DEC      = 17'h00800,
    S_VAL           = 17'h01000,
    S_FA_RD         = 17'h02000,
    S_FA_CHK        = 17'h04000,
    S_FA_DEC        = 17'h08000,
    S_RESP          = 17'h10000
  } state_t;

  state_t   state_r, state_nxt;
  status_t  rsp_st_r, rsp_st_nxt;
  idx_sel_t rsp_sel_r, rsp_sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      rsp_st_r  <= ST_OK;
      rsp_sel_r <= SEL_ZERO;
    end else begin
      state_r   <= state_nxt;
      rsp_st_r  <= rsp_st_nxt;
      rsp_sel_r <= rsp_sel_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    rsp_st_nxt  = rsp_st_r;
    rsp_sel_nxt = rsp_sel_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last_clr) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.cnt_clr   = 1'b1;
        cmd.found_clr = 1'b1;
        if (stat.bad_id) begin
          rsp_st_nxt  = ST_BAD_ID;
          rsp_sel_nxt = SEL_ZERO;
          state_nxt   = S_RESP;
        end else if (stat.kind == KIND_FREE_ALL) begin
          state_nxt = S_FA_RD;
        end else begin
          state_nxt = S_SCAN_SLOT;
        end
      end
      S_SCAN_SLOT: begin
        cmd.slot_rd   = 1'b1;
        cmd.slot_scan = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (stat.cnt_last_slot) begin
          state_nxt = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.kind == KIND_GET) begin
          if (stat.id_new) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_SCAN_REF;
          end else if (stat.held_found) begin
            rsp_st_nxt  = ST_OK;
            rsp_sel_nxt = SEL_ID;
            state_nxt   = S_RESP;
          end else begin
            cmd.ref_rd_id = 1'b1;
            state_nxt     = S_GET_REF;
          end
        end else if (!stat.held_found) begin
          rsp_st_nxt  = ST_NOT_HELD;
          rsp_sel_nxt = SEL_ZERO;
          state_nxt   = S_RESP;
        end else if (stat.kind == KIND_FREE) begin
          cmd.ref_rd_id     = 1'b1;
          cmd.slot_clr_held = 1'b1;
          state_nxt         = S_FREE_DEC;
        end else if (stat.kind inside {KIND_DOWN, KIND_UP}) begin
          cmd.val_rd = 1'b1;
          state_nxt  = S_VAL;
        end else begin
          rsp_st_nxt  = ST_BAD_ID;
          rsp_sel_nxt = SEL_ZERO;
          state_nxt   = S_RESP;
        end
      end
      S_GET_REF: begin
        // an existing id can only be attached while someone references it
        if (!stat.ref_zero) begin
          cmd.chosen_from_id = 1'b1;
          state_nxt          = S_ATTACH;
        end else begin
          rsp_st_nxt  = ST_BAD_ID;
          rsp_sel_nxt = SEL_ZERO;
          state_nxt   = S_RESP;
        end
      end
      S_SCAN_REF: begin
        cmd.ref_rd_scan = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (stat.cnt_last_sem) begin
          state_nxt = S_SCAN_REF_LAST;
        end
      end
      S_SCAN_REF_LAST: begin
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        if (!stat.chosen_found) begin
          rsp_st_nxt  = ST_NONE_FREE;
          rsp_sel_nxt = SEL_ZERO;
          state_nxt   = S_RESP;
        end else begin
          // value is written even when no slot turns out to be free
          cmd.val_wr_init   = 1'b1;
          cmd.ref_rd_chosen = 1'b1;
          state_nxt         = S_ATTACH;
        end
      end
      S_ATTACH: begin
        if (!stat.free_found) begin
          rsp_st_nxt  = ST_NO_SLOT;
          rsp_sel_nxt = SEL_ZERO;
        end else begin
          cmd.slot_attach       = 1'b1;
          cmd.ref_wr_inc_chosen = 1'b1;
          rsp_st_nxt            = ST_OK;
          rsp_sel_nxt           = SEL_CHOSEN;
        end
        state_nxt = S_RESP;
      end
      S_FREE_DEC: begin
        cmd.ref_wr_dec_id = 1'b1;
        rsp_st_nxt        = ST_OK;
        rsp_sel_nxt       = SEL_ID;
        state_nxt         = S_RESP;
      end
      S_VAL: begin
        if (stat.kind == KIND_DOWN) begin
          if (stat.val_pos) begin
            cmd.val_wr_down = 1'b1;
            rsp_st_nxt      = ST_OK;
            rsp_sel_nxt     = SEL_ID;
          end else begin
            rsp_st_nxt  = ST_WOULD_BLOCK;
            rsp_sel_nxt = SEL_ZERO;
          end
        end else begin
          cmd.val_wr_up = 1'b1;
          rsp_st_nxt    = ST_OK;
          rsp_sel_nxt   = SEL_ID;
        end
        state_nxt = S_RESP;
      end
      S_FA_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_FA_CHK;
      end
      S_FA_CHK: begin
        if (stat.slot_valid) begin
          cmd.slot_clr_cur = 1'b1;
          cmd.ref_rd_slot  = 1'b1;
          state_nxt        = S_FA_DEC;
        end else if (stat.cnt_last_slot) begin
          rsp_st_nxt  = ST_OK;
          rsp_sel_nxt = SEL_ZERO;
          state_nxt   = S_RESP;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FA_RD;
        end
      end
      S_FA_DEC: begin
        cmd.ref_wr_dec_slot = 1'b1;
        if (stat.cnt_last_slot) begin
          rsp_st_nxt  = ST_OK;
          rsp_sel_nxt = SEL_ZERO;
          state_nxt   = S_RESP;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FA_RD;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = rsp_st_r;
          cmd.out_sel    = rsp_sel_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/cst_datapath.sv -----
// ----------------------------------------------------------------------------
// cst_datapath
// Request register, handle-slot / reference-count / value memories, scan
// counter with first-match tracking, and the result register.
// ----------------------------------------------------------------------------
module cst_datapath #(
  parameter int NUM_SEMS          = cst_pkg::NUM_SEMS_DEF,
  parameter int SLOTS_PER_PROCESS = cst_pkg::SLOTS_DEF,
  parameter int NUM_PROCESSES     = cst_pkg::NUM_PROCESSES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [cst_pkg::KIND_W-1:0]          in_kind,
  input  logic [cst_pkg::PID_W-1:0]           in_process_id,
  input  logic signed [cst_pkg::ID_W-1:0]     in_sem_id,
  input  logic signed [cst_pkg::VAL_W-1:0]    in_init_value,
  input  cst_pkg::cmd_t                       cmd,
  output cst_pkg::stat_t                      stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cst_pkg::STATUS_W-1:0]        out_status,
  output logic [cst_pkg::IDX_W-1:0]           out_sem_index
);
  import cst_pkg::*;

  localparam int SemW       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int TotalSlots = NUM_PROCESSES * SLOTS_PER_PROCESS;
  localparam int SlotAw     = (TotalSlots > 1) ? $clog2(TotalSlots) : 1;
  localparam int ClrLen     = (TotalSlots > NUM_SEMS) ? TotalSlots : NUM_SEMS;
  localparam int CntW       = $clog2(ClrLen + 1);
  localparam int KW         = (SLOTS_PER_PROCESS > 1) ? $clog2(SLOTS_PER_PROCESS) : 1;

  // request
  logic [KIND_W-1:0] req_kind_r;
  logic [PID_W-1:0]  req_pid_r;
  logic [ID_W-1:0]   req_id_r;
  logic [VAL_W-1:0]  req_iv_r;

  // scan state
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] eval_idx_r;
  logic            slot_eval_r, ref_eval_r;
  logic            held_found_r, held_found_nxt;
  logic            free_found_r, free_found_nxt;
  logic            chosen_found_r, chosen_found_nxt;
  logic [KW-1:0]   held_k_r, held_k_nxt;
  logic [KW-1:0]   free_k_r, free_k_nxt;
  logic [SemW-1:0] chosen_r, chosen_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0]    out_index_r, out_index_nxt;

  // memories; a slot entry is {valid, semaphore}
  logic [SemW:0]             slot_mem [TotalSlots];
  logic [SemW:0]             slot_rdata_r;
  logic [REF_W-1:0]          ref_mem [NUM_SEMS];
  logic [REF_W-1:0]          ref_rdata_r;
  logic signed [VAL_W-1:0]   val_mem [NUM_SEMS];
  logic signed [VAL_W-1:0]   val_rdata_r;

  logic [SemW-1:0]   id_sem;
  logic [SlotAw-1:0] addr_cur, addr_held, addr_free;
  logic              slot_we;
  logic [SlotAw-1:0] slot_waddr;
  logic [SemW:0]     slot_wdata;
  logic [SemW-1:0]   ref_raddr;
  logic              ref_we;
  logic [SemW-1:0]   ref_waddr;
  logic [REF_W-1:0]  ref_wdata;
  logic [REF_W-1:0]  ref_inc, ref_dec;
  logic              val_we;
  logic [SemW-1:0]   val_waddr;
  logic [VAL_W-1:0]  val_wdata;
  logic              kind_ok, pid_bad, id_big, get_bad, use_bad;
  int                slot_base;

  assign id_sem = SemW'(req_id_r[IDX_W-1:0]);

  always_comb begin
    slot_base = int'(req_pid_r) * SLOTS_PER_PROCESS;
    addr_cur  = SlotAw'(slot_base + int'(cnt_r));
    addr_held = SlotAw'(slot_base + int'(held_k_r));
    addr_free = SlotAw'(slot_base + int'(free_k_r));
  end

  // request decode
  always_comb begin
    kind_ok = (req_kind_r <= KIND_FREE_ALL);
    pid_bad = int'(req_pid_r) >= NUM_PROCESSES;
    id_big  = !req_id_r[ID_W-1] && (int'(req_id_r[IDX_W-1:0]) >= NUM_SEMS);
    get_bad = (req_kind_r == KIND_GET) && req_id_r[ID_W-1] && (req_id_r != ID_NEW);
    use_bad = (req_kind_r inside {KIND_FREE, KIND_DOWN, KIND_UP}) && req_id_r[ID_W-1];
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_kind_r <= in_kind;
      req_pid_r  <= in_process_id;
      req_id_r   <= in_sem_id;
      req_iv_r   <= in_init_value;
    end
  end

  // scan counter and first-match tracking, evaluated in the cycle after each read
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CntW'(1);
    end

    held_found_nxt   = held_found_r;
    free_found_nxt   = free_found_r;
    chosen_found_nxt = chosen_found_r;
    held_k_nxt       = held_k_r;
    free_k_nxt       = free_k_r;
    chosen_nxt       = chosen_r;
    if (cmd.found_clr) begin
      held_found_nxt   = 1'b0;
      free_found_nxt   = 1'b0;
      chosen_found_nxt = 1'b0;
    end else begin
      if (slot_eval_r) begin
        if (slot_rdata_r[SemW] && (slot_rdata_r[SemW-1:0] == id_sem) && !held_found_r) begin
          held_found_nxt = 1'b1;
          held_k_nxt     = KW'(eval_idx_r);
        end
        if (!slot_rdata_r[SemW] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_k_nxt     = KW'(eval_idx_r);
        end
      end
      if (ref_eval_r && (ref_rdata_r == '0) && !chosen_found_r) begin
        chosen_found_nxt = 1'b1;
        chosen_nxt       = SemW'(eval_idx_r);
      end
    end
    if (cmd.chosen_from_id) begin
      chosen_nxt = id_sem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r          <= '0;
      slot_eval_r    <= 1'b0;
      ref_eval_r     <= 1'b0;
      held_found_r   <= 1'b0;
      free_found_r   <= 1'b0;
      chosen_found_r <= 1'b0;
    end else begin
      cnt_r          <= cnt_nxt;
      slot_eval_r    <= cmd.slot_rd && cmd.slot_scan;
      ref_eval_r     <= cmd.ref_rd_scan;
      held_found_r   <= held_found_nxt;
      free_found_r   <= free_found_nxt;
      chosen_found_r <= chosen_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= cnt_r;
    held_k_r   <= held_k_nxt;
    free_k_r   <= free_k_nxt;
    chosen_r   <= chosen_nxt;
  end

  // handle slots
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = addr_cur;
    slot_wdata = '0;
    if (cmd.clr_wr) begin
      slot_we    = int'(cnt_r) < TotalSlots;
      slot_waddr = cnt_r[SlotAw-1:0];
    end else if (cmd.slot_clr_held) begin
      slot_we    = 1'b1;
      slot_waddr = addr_held;
    end else if (cmd.slot_clr_cur) begin
      slot_we    = 1'b1;
      slot_waddr = addr_cur;
    end else if (cmd.slot_attach) begin
      slot_we    = 1'b1;
      slot_waddr = addr_free;
      slot_wdata = {1'b1, chosen_r};
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (cmd.slot_rd) begin
      slot_rdata_r <= slot_mem[addr_cur];
    end
  end

  // reference counts
  assign ref_inc = (ref_rdata_r == REF_MAX) ? ref_rdata_r : ref_rdata_r + REF_W'(1);
  assign ref_dec = (ref_rdata_r == '0) ? ref_rdata_r : ref_rdata_r - REF_W'(1);

  always_comb begin
    ref_raddr = id_sem;
    if (cmd.ref_rd_scan) begin
      ref_raddr = cnt_r[SemW-1:0];
    end else if (cmd.ref_rd_chosen) begin
      ref_raddr = chosen_r;
    end else if (cmd.ref_rd_slot) begin
      ref_raddr = slot_rdata_r[SemW-1:0];
    end

    ref_we    = 1'b0;
    ref_waddr = id_sem;
    ref_wdata = ref_dec;
    if (cmd.clr_wr) begin
      ref_we    = int'(cnt_r) < NUM_SEMS;
      ref_waddr = cnt_r[SemW-1:0];
      ref_wdata = '0;
    end else if (cmd.ref_wr_inc_chosen) begin
      ref_we    = 1'b1;
      ref_waddr = chosen_r;
      ref_wdata = ref_inc;
    end else if (cmd.ref_wr_dec_id) begin
      ref_we = 1'b1;
    end else if (cmd.ref_wr_dec_slot) begin
      // slot data still holds the entry being released
      ref_we    = 1'b1;
      ref_waddr = slot_rdata_r[SemW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (cmd.ref_rd_id || cmd.ref_rd_scan || cmd.ref_rd_chosen || cmd.ref_rd_slot) begin
      ref_rdata_r <= ref_mem[ref_raddr];
    end
  end

  // semaphore values
  always_comb begin
    val_we    = 1'b0;
    val_waddr = id_sem;
    val_wdata = val_rdata_r;
    if (cmd.val_wr_init) begin
      val_we    = 1'b1;
      val_waddr = chosen_r;
      val_wdata = req_iv_r;
    end else if (cmd.val_wr_down) begin
      val_we    = 1'b1;
      val_wdata = val_rdata_r - VAL_W'(1);
    end else if (cmd.val_wr_up) begin
      val_we    = 1'b1;
      val_wdata = (val_rdata_r == VAL_MAX) ? val_rdata_r : val_rdata_r + VAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (cmd.val_rd) begin
      val_rdata_r <= val_mem[id_sem];
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.out_status;
      case (cmd.out_sel)
        SEL_ZERO:   out_index_nxt = '0;
        SEL_ID:     out_index_nxt = req_id_r[IDX_W-1:0];
        SEL_CHOSEN: out_index_nxt = IDX_W'(chosen_r);
        default:    out_index_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_sem_index = out_index_r;

  always_comb begin
    stat               = '0;
    stat.kind          = req_kind_r;
    stat.bad_id        = pid_bad || !kind_ok || id_big || get_bad || use_bad;
    stat.id_new        = (req_id_r == ID_NEW);
    stat.held_found    = held_found_r;
    stat.free_found    = free_found_r;
    stat.chosen_found  = chosen_found_r;
    stat.slot_valid    = slot_rdata_r[SemW];
    stat.ref_zero      = (ref_rdata_r == '0);
    stat.val_pos       = !val_rdata_r[VAL_W-1] && (val_rdata_r != '0);
    stat.cnt_last_slot = (cnt_r == CntW'(SLOTS_PER_PROCESS - 1));
    stat.cnt_last_sem  = (cnt_r == CntW'(NUM_SEMS - 1));
    stat.cnt_last_clr  = (cnt_r == CntW'(ClrLen - 1));
    stat.out_busy      = out_valid_r && !out_ready;
  end

endmodule

// ----- src/counting_semaphore_table.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores with per-process handle slots; one request in,
// one status/index result out.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over max(NUM_PROCESSES *
// SLOTS_PER_PROCESS, NUM_SEMS) entries (512 with the defaults) during which
// in_ready stays low. It then serves one request at a time. Every request
// other than a rejected one scans the process's handle slots from a
// single-port slot memory, one slot per cycle. Down, up and free then do
// their update, get of an already held semaphore goes straight to the
// result and get that attaches an existing semaphore first reads its
// reference count. Get of a new semaphore also scans the reference-count
// memory one entry per cycle. Free-all walks the handle slots with a
// read-modify-write of the reference count per held slot. A request with a
// bad id goes from decode straight to the result. in_ready rises in the
// same cycle as the result appears. Results wait in an output register
// until taken.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
  parameter int NUM_SEMS          = cst_pkg::NUM_SEMS_DEF,
  parameter int SLOTS_PER_PROCESS = cst_pkg::SLOTS_DEF,
  parameter int NUM_PROCESSES     = cst_pkg::NUM_PROCESSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cst_pkg::KIND_W-1:0]       in_kind,
  input  logic [cst_pkg::PID_W-1:0]        in_process_id,
  input  logic signed [cst_pkg::ID_W-1:0]  in_sem_id,
  input  logic signed [cst_pkg::VAL_W-1:0] in_init_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cst_pkg::STATUS_W-1:0]     out_status,
  output logic [cst_pkg::IDX_W-1:0]        out_sem_index
);
  import cst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cst_datapath #(
    .NUM_SEMS          (NUM_SEMS),
    .SLOTS_PER_PROCESS (SLOTS_PER_PROCESS),
    .NUM_PROCESSES     (NUM_PROCESSES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_kind),
    .in_process_id (in_process_id),
    .in_sem_id     (in_sem_id),
    .in_init_value (in_init_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_sem_index (out_sem_index)
  );

endmodule
